@@ design/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

   // command codes
   localparam logic [2:0] CMD_CLEAR   = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_READ    = 3'd2;
   localparam logic [2:0] CMD_RESERVE = 3'd3;
   localparam logic [2:0] CMD_FIND    = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;

   localparam logic [10:0] WORDS_RESET = 11'd1024;
   localparam int          FRAME_SHIFT = 12;

   // operation of the shared word unit
   typedef enum logic [1:0] {
      OP_SET_BIT = 2'd0,
      OP_GET_BIT = 2'd1,
      OP_PREFIX  = 2'd2
   } word_op_type;

   typedef struct packed {
      word_op_type op;
      logic [4:0]  pos;
      logic        value;
      logic [4:0]  rem;
   } word_ctl_type;

   typedef struct packed {
      logic [31:0] new_word;
      logic        bit_rd;
      logic        all_used;
      logic [4:0]  free_pos;
   } word_res_type;

endpackage

@@ design/fba_map_ram.sv @@
`timescale 1ns / 1ps

module fba_map_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fba_word_unit.sv @@
`timescale 1ns / 1ps

module fba_word_unit (
   input  logic                 [31:0] word,
   input  fba_pkg::word_ctl_type       ctl,
   output fba_pkg::word_res_type       res
);

   logic [31:0] mask;
   logic [4:0]  first_free;

   // frame order is msb first
   assign mask = 32'h8000_0000 >> ctl.pos;

   // lowest frame whose bit is clear
   always_comb begin
      first_free = 5'd0;
      for (int j = 31; j >= 0; j--) begin
         if (!word[31 - j]) begin
            first_free = 5'(j);
         end
      end
   end

   always_comb begin
      res.bit_rd   = |(word & mask);
      res.all_used = &word;
      res.free_pos = first_free;
      case (ctl.op)
         fba_pkg::OP_SET_BIT: begin
            res.new_word = ctl.value ? (word | mask) : (word & ~mask);
         end
         fba_pkg::OP_PREFIX: begin
            res.new_word = word | ~(32'hFFFF_FFFF >> ctl.rem);
         end
         default: begin
            res.new_word = word;
         end
      endcase
   end

endmodule

@@ design/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps

// Frame bitmap allocator: one used/free bit per memory frame, 32 frames per word,
// lowest frame in the msb. Commands arrive on the req_ valid/ready channel and each
// gives exactly one transaction on the rsp_ channel (status, bit read, free index).
// csr_wr_en/csr_wr_data set the number of words in use; write it only while idle.
// Steps per command, up to the result register loading:
//   read / write bit          registered read of the word, then write-back (write) or report (read)
//   out of range, unknown cmd range status, no map access
//   clear all                 every word in use written with zeros
//   reserve prefix            full words set, then any partial word merged
//   find free                 words in use read in order, one word per cycle
// All of these share the single map memory port pair and the shared word unit.
// A new command is accepted once the sequencer is idle and the result register is
// empty or being emptied; a stalled receiver holds the sequencer at its final step.
// After reset all MAX_WORDS words of the map are cleared in a pass during which no
// command is accepted; configuration writes are taken throughout.
module frame_bitmap_allocator #(
   parameter int MAX_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [14:0] req_frame_index,
   input  logic        req_bit_value,
   input  logic [31:0] req_byte_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_bit_read,
   output logic [14:0] rsp_free_index,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_RMW    = 4'b0010,
      S_FILL   = 4'b0100,
      S_SEARCH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [CNT_W-1:0]     ridx_ff, ridx_in;
   logic [4:0]           rem_ff, rem_in;
   logic                 report_ff, report_in;
   logic                 fill_val_ff, fill_val_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        addr_ff, addr_in;
   fba_pkg::word_op_type op_ff, op_in;
   logic [4:0]           pos_ff, pos_in;
   logic                 val_ff, val_in;
   logic [10:0]          words_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic                 bit_ff, bit_in;
   logic [14:0]          free_ff, free_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [31:0]           ram_wdata, ram_rdata;
   fba_pkg::word_ctl_type ctl;
   fba_pkg::word_res_type res;

   logic [16:0]      n_wide;
   logic [CNT_W-1:0] n_live;
   logic [16:0]      word_sel;
   logic             out_free;
   logic             accept;
   logic [19:0]      rsv_frames;
   logic [21:0]      frame_limit;
   logic [16:0]      full_wide;
   logic [31:0]      found_wide;

   // effective word count saturates at the map size
   assign n_wide = (17'(words_ff) > 17'(MAX_WORDS)) ? 17'(MAX_WORDS) : 17'(words_ff);
   assign n_live = n_wide[CNT_W-1:0];

   assign word_sel    = 17'(req_frame_index[14:5]);
   assign rsv_frames  = req_byte_size[31:fba_pkg::FRAME_SHIFT];
   assign frame_limit = {n_wide, 5'd0};
   assign full_wide   = 17'(rsv_frames[19:5]);
   assign found_wide  = 32'({ridx_ff, res.free_pos});

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign ctl.op    = op_ff;
   assign ctl.pos   = pos_ff;
   assign ctl.value = val_ff;
   assign ctl.rem   = rem_ff;

   fba_map_ram #(
      .DEPTH (MAX_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   fba_word_unit u_word_unit (
      .word (ram_rdata),
      .ctl  (ctl),
      .res  (res)
   );

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      ridx_in      = ridx_ff;
      rem_in       = rem_ff;
      report_in    = report_ff;
      fill_val_in  = fill_val_ff;
      pend_in      = pend_ff;
      addr_in      = addr_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      bit_in       = bit_ff;
      free_in      = free_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = fba_pkg::ST_OK;
               bit_in    = 1'b0;
               free_in   = '0;
               case (req_cmd)
                  fba_pkg::CMD_CLEAR: begin
                     cnt_in      = '0;
                     end_in      = n_live;
                     rem_in      = 5'd0;
                     report_in   = 1'b1;
                     fill_val_in = 1'b0;
                     state_in    = S_FILL;
                  end
                  fba_pkg::CMD_WRITE, fba_pkg::CMD_READ: begin
                     if (word_sel >= n_wide) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fba_pkg::ST_RANGE;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = word_sel[AW-1:0];
                        addr_in   = word_sel[AW-1:0];
                        pos_in    = req_frame_index[4:0];
                        val_in    = req_bit_value;
                        op_in     = (req_cmd == fba_pkg::CMD_WRITE) ?
                                    fba_pkg::OP_SET_BIT : fba_pkg::OP_GET_BIT;
                        state_in  = S_RMW;
                     end
                  end
                  fba_pkg::CMD_RESERVE: begin
                     if (22'(rsv_frames) > frame_limit) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fba_pkg::ST_RANGE;
                     end else begin
                        cnt_in      = '0;
                        end_in      = full_wide[CNT_W-1:0];
                        rem_in      = rsv_frames[4:0];
                        report_in   = 1'b1;
                        fill_val_in = 1'b1;
                        op_in       = fba_pkg::OP_PREFIX;
                        state_in    = S_FILL;
                     end
                  end
                  fba_pkg::CMD_FIND: begin
                     cnt_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = fba_pkg::ST_RANGE;
                  end
               endcase
            end
         end

         // word read last cycle is merged and written back or reported
         S_RMW: begin
            if (out_free) begin
               if (op_ff != fba_pkg::OP_GET_BIT) begin
                  ram_we    = 1'b1;
                  ram_waddr = addr_ff;
                  ram_wdata = res.new_word;
               end
               rsp_valid_in = 1'b1;
               status_in    = fba_pkg::ST_OK;
               bit_in       = (op_ff == fba_pkg::OP_GET_BIT) ? res.bit_rd : 1'b0;
               free_in      = '0;
               state_in     = S_IDLE;
            end
         end

         // write whole words, then merge a partial word if any
         S_FILL: begin
            if (cnt_ff < end_ff) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff[AW-1:0];
               ram_wdata = {32{fill_val_ff}};
               cnt_in    = cnt_ff + 1'b1;
            end else if (rem_ff != 5'd0) begin
               ram_re    = 1'b1;
               ram_raddr = end_ff[AW-1:0];
               addr_in   = end_ff[AW-1:0];
               state_in  = S_RMW;
            end else if (!report_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = fba_pkg::ST_OK;
               bit_in       = 1'b0;
               free_in      = '0;
               state_in     = S_IDLE;
            end
         end

         // one word read per cycle, checked the cycle after
         S_SEARCH: begin
            if (pend_ff && !res.all_used) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  status_in    = fba_pkg::ST_OK;
                  bit_in       = 1'b0;
                  free_in      = found_wide[14:0];
                  pend_in      = 1'b0;
                  state_in     = S_IDLE;
               end
            end else if (cnt_ff < n_live) begin
               ram_re    = 1'b1;
               ram_raddr = cnt_ff[AW-1:0];
               ridx_in   = cnt_ff;
               pend_in   = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = fba_pkg::ST_NONE;
               bit_in       = 1'b0;
               free_in      = '0;
               pend_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               pend_in = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         cnt_ff       <= '0;
         end_ff       <= CNT_W'(MAX_WORDS);
         rem_ff       <= 5'd0;
         report_ff    <= 1'b0;
         fill_val_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         words_ff     <= fba_pkg::WORDS_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
         rem_ff       <= rem_in;
         report_ff    <= report_in;
         fill_val_ff  <= fill_val_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            words_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ridx_ff   <= ridx_in;
      addr_ff   <= addr_in;
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      bit_ff    <= bit_in;
      free_ff   <= free_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_bit_read   = bit_ff;
   assign rsp_free_index = free_ff;

endmodule
